// File: src/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
// Every other file of the block imports this package; it depends on nothing.
package afs_pkg;

  localparam int FRAME_BITS    = 16;
  localparam int STEP_BITS     = 9;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_DELTA = 2'd2;

  localparam int RESET_START = 1;
  localparam int RESET_END   = 100;
  localparam int RESET_DELTA = 1;

  typedef enum logic [2:0] {
    OP_STOP,
    OP_PAUSE,
    OP_PLAY,
    OP_STEP,
    OP_SET_DIR,
    OP_SET_LOOP,
    OP_SET_PAL,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOP,
    MODE_PAUSE,
    MODE_STEP,
    MODE_PLAY
  } mode_t;

  typedef logic signed [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    op_t  op;
    logic setting;
  } cmd_t;

  typedef struct packed {
    frame_t start_frame;
    frame_t end_frame;
    frame_t frame_delta;
  } cfg_t;

  typedef struct packed {
    logic   frame_issued;
    frame_t issued_frame;
    frame_t upcoming_frame;
    mode_t  play_mode;
    logic   playback_done;
  } res_t;

endpackage

// File: src/afs_front.sv
// Front end of the frame sequencer: accepts input beats, decodes the operation
// and holds the decoded commands in a two-entry queue. Depends on afs_pkg.
module afs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [2:0]          operation,
  input  logic                setting,
  output logic                full,
  output logic                cmd_valid,
  output afs_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);
  import afs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       decoded;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    decoded.op      = op_t'(operation);
    decoded.setting = setting;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

// File: src/afs_res_fifo.sv
// Two-entry result queue that parts the sequencer core from the result port.
// Depends on afs_pkg for the result type.
module afs_res_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  afs_pkg::res_t wr_data,
  output logic          wr_full,
  output logic          rd_valid,
  output afs_pkg::res_t rd_data,
  input  logic          rd_pop
);
  import afs_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign wr_full  = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = wr_en && !wr_full;
  assign do_pop   = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/afs_back.sv
// Back end of the frame sequencer: holds the playback state and carries out one
// decoded command per cycle into the result queue while it has room. Depends on afs_pkg.
module afs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  afs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  afs_pkg::cfg_t cfg,
  input  logic          res_full,
  output logic          res_wr,
  output afs_pkg::res_t res
);
  import afs_pkg::*;

  // Two guard bits cover the delta magnitude and the sum overshooting the range.
  localparam int WB = FRAME_BITS + 2;
  typedef logic signed [WB-1:0] wide_t;
  typedef logic signed [STEP_BITS-1:0] step_t;
  typedef struct packed {
    frame_t nf;
    logic   flipped;
    logic   stop;
  } adv_t;

  localparam step_t STEP_MAX  = {1'b0, {(STEP_BITS-1){1'b1}}};
  localparam step_t STEP_MIN  = {1'b1, {(STEP_BITS-1){1'b0}}};
  localparam step_t STEP_ONE  = step_t'(1);
  localparam step_t STEP_ZERO = step_t'(0);

  function automatic wide_t clamp(wide_t n, wide_t s, wide_t e);
    if (n < s) begin
      return s;
    end
    if (n > e) begin
      return e;
    end
    return n;
  endfunction

  function automatic adv_t advance(frame_t nf, wide_t s, wide_t e, wide_t d,
                                   logic bwd, logic flp, logic lp, logic pal);
    wide_t base;
    wide_t step;
    wide_t n;
    logic  high;
    adv_t  r;
    base      = wide_t'(nf);
    step      = (bwd ^ flp) ? -d : d;
    n         = base + step;
    high      = (n > e);
    r.nf      = nf;
    r.flipped = flp;
    r.stop    = 1'b0;
    if (n >= s && n <= e) begin
      r.nf = frame_t'(n);
    end else begin
      if (lp) begin
        if (pal) begin
          r.flipped = !flp;
          n = base - step;
        end else begin
          n = high ? s : e;
        end
      end else if (pal) begin
        if (flp) begin
          r.flipped = 1'b0;
          r.stop    = 1'b1;
          n = high ? e : s;
        end else begin
          r.flipped = 1'b1;
          n = base - step;
        end
      end else begin
        n = high ? s : e;
        r.stop = 1'b1;
      end
      r.nf = frame_t'(clamp(n, s, e));
    end
    return r;
  endfunction

  // A reposition moves the next frame by two advances, but only from inside the range.
  function automatic adv_t reposition(frame_t nf, wide_t s, wide_t e, wide_t d,
                                      logic bwd, logic flp, logic lp, logic pal);
    adv_t a1;
    adv_t a2;
    adv_t r;
    r.nf      = nf;
    r.flipped = flp;
    r.stop    = 1'b0;
    if (clamp(wide_t'(nf), s, e) == wide_t'(nf)) begin
      a1 = advance(nf, s, e, d, bwd, flp, lp, pal);
      a2 = advance(a1.nf, s, e, d, bwd, a1.flipped, lp, pal);
      r.nf      = a2.nf;
      r.flipped = a2.flipped;
      r.stop    = a1.stop | a2.stop;
    end
    return r;
  endfunction

  frame_t next_frame;
  mode_t  mode;
  logic   backward;
  logic   loop_on;
  logic   palindrome_on;
  logic   flipped;
  step_t  pending_steps;

  frame_t next_frame_next;
  mode_t  mode_next;
  logic   backward_next;
  logic   loop_on_next;
  logic   palindrome_on_next;
  logic   flipped_next;
  step_t  pending_steps_next;
  logic   issued;

  wide_t  s_w;
  wide_t  e_w;
  wide_t  d_raw;
  wide_t  d_mag;
  adv_t   adv;
  logic   fire;

  assign fire    = cmd_valid && !res_full;
  assign cmd_pop = fire;
  assign res_wr  = fire;

  assign s_w   = wide_t'(cfg.start_frame);
  assign e_w   = wide_t'(cfg.end_frame);
  assign d_raw = wide_t'(cfg.frame_delta);

  always_comb begin
    if (d_raw == wide_t'(0)) begin
      d_mag = wide_t'(1);
    end else if (d_raw < wide_t'(0)) begin
      d_mag = -d_raw;
    end else begin
      d_mag = d_raw;
    end
  end

  always_comb begin
    next_frame_next    = next_frame;
    mode_next          = mode;
    backward_next      = backward;
    loop_on_next       = loop_on;
    palindrome_on_next = palindrome_on;
    flipped_next       = flipped;
    pending_steps_next = pending_steps;
    issued             = 1'b0;
    adv                = '0;
    unique case (cmd.op)
      OP_STOP: begin
        mode_next          = MODE_STOP;
        flipped_next       = 1'b0;
        pending_steps_next = '0;
      end
      OP_PAUSE: begin
        mode_next = MODE_PAUSE;
      end
      OP_PLAY: begin
        mode_next          = MODE_PLAY;
        flipped_next       = 1'b0;
        pending_steps_next = '0;
      end
      OP_STEP: begin
        if (backward) begin
          if (pending_steps > STEP_MIN) begin
            pending_steps_next = pending_steps - STEP_ONE;
          end
        end else begin
          if (pending_steps < STEP_MAX) begin
            pending_steps_next = pending_steps + STEP_ONE;
          end
        end
        mode_next = (pending_steps_next != '0) ? MODE_STEP : MODE_STOP;
      end
      OP_SET_DIR: begin
        if (backward != cmd.setting) begin
          backward_next = cmd.setting;
          adv = reposition(next_frame, s_w, e_w, d_mag, cmd.setting, flipped,
                           loop_on, palindrome_on);
          next_frame_next = adv.nf;
          flipped_next    = adv.flipped;
          if (adv.stop) begin
            mode_next = MODE_STOP;
          end
        end
      end
      OP_SET_LOOP: begin
        loop_on_next = cmd.setting;
      end
      OP_SET_PAL: begin
        palindrome_on_next = cmd.setting;
        if (flipped) begin
          adv = reposition(next_frame, s_w, e_w, d_mag, backward, 1'b0,
                           loop_on, cmd.setting);
          next_frame_next = adv.nf;
          flipped_next    = adv.flipped;
          if (adv.stop) begin
            mode_next = MODE_STOP;
          end
        end
      end
      OP_DONE: begin
        if (mode == MODE_PLAY || mode == MODE_STEP) begin
          issued = 1'b1;
          adv = advance(frame_t'(clamp(wide_t'(next_frame), s_w, e_w)), s_w, e_w,
                        d_mag, backward, flipped, loop_on, palindrome_on);
          next_frame_next = adv.nf;
          flipped_next    = adv.flipped;
          if (adv.stop) begin
            mode_next = MODE_STOP;
          end
          if (mode == MODE_STEP) begin
            pending_steps_next = (pending_steps < STEP_ZERO) ? pending_steps + STEP_ONE
                                                             : pending_steps - STEP_ONE;
            if (pending_steps_next == '0) begin
              mode_next = MODE_STOP;
            end
          end
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  always_comb begin
    res.frame_issued   = issued;
    res.issued_frame   = issued ? next_frame : '0;
    res.upcoming_frame = next_frame_next;
    res.play_mode      = mode_next;
    res.playback_done  = (mode_next == MODE_STOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_frame    <= frame_t'(RESET_START);
      mode          <= MODE_STOP;
      backward      <= 1'b0;
      loop_on       <= 1'b0;
      palindrome_on <= 1'b0;
      flipped       <= 1'b0;
      pending_steps <= '0;
    end else if (fire) begin
      next_frame    <= next_frame_next;
      mode          <= mode_next;
      backward      <= backward_next;
      loop_on       <= loop_on_next;
      palindrome_on <= palindrome_on_next;
      flipped       <= flipped_next;
      pending_steps <= pending_steps_next;
    end
  end

endmodule

// File: src/animation_frame_sequencer_unit.sv
// Animation frame sequencer, top level. Uses afs_pkg, afs_front, afs_back, afs_res_fifo.
// Path: a pushed item waits in the afs_front command queue, is carried out by afs_back,
// and its result is registered in afs_res_fifo before it reaches the result ports.
// Throughput: one item per cycle in afs_back while the result queue has room.
// Reset (rst, synchronous): queues empty, playback state and range registers to reset values.
module animation_frame_sequencer_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [2:0]                             operation,
  input  logic                                   setting,
  output logic                                   empty,
  input  logic                                   pop,
  output logic                                   frame_issued,
  output logic signed [afs_pkg::FRAME_BITS-1:0]  issued_frame,
  output logic signed [afs_pkg::FRAME_BITS-1:0]  upcoming_frame,
  output logic [1:0]                             play_mode,
  output logic                                   playback_done,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [afs_pkg::CFG_ADDR_BITS-1:0]      paddr,
  input  logic [afs_pkg::CFG_DATA_BITS-1:0]      pwdata,
  output logic [afs_pkg::CFG_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);
  import afs_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  res_t       res_in;
  res_t       res_out;
  logic       cmd_valid;
  logic       cmd_pop;
  logic       res_wr;
  logic       res_full;
  logic       res_valid;
  logic       cfg_write;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_frame <= frame_t'(RESET_START);
      cfg.end_frame   <= frame_t'(RESET_END);
      cfg.frame_delta <= frame_t'(RESET_DELTA);
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_START: cfg.start_frame <= frame_t'(pwdata[FRAME_BITS-1:0]);
        REG_END:   cfg.end_frame   <= frame_t'(pwdata[FRAME_BITS-1:0]);
        REG_DELTA: cfg.frame_delta <= frame_t'(pwdata[FRAME_BITS-1:0]);
        default:   cfg.frame_delta <= cfg.frame_delta;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_START: prdata = CFG_DATA_BITS'($unsigned(cfg.start_frame));
      REG_END:   prdata = CFG_DATA_BITS'($unsigned(cfg.end_frame));
      REG_DELTA: prdata = CFG_DATA_BITS'($unsigned(cfg.frame_delta));
      default:   prdata = '0;
    endcase
  end

  afs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .operation (operation),
    .setting   (setting),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  afs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  afs_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_wr),
    .wr_data  (res_in),
    .wr_full  (res_full),
    .rd_valid (res_valid),
    .rd_data  (res_out),
    .rd_pop   (pop)
  );

  assign empty          = !res_valid;
  assign frame_issued   = res_out.frame_issued;
  assign issued_frame   = res_out.issued_frame;
  assign upcoming_frame = res_out.upcoming_frame;
  assign play_mode      = res_out.play_mode;
  assign playback_done  = res_out.playback_done;

`ifndef SYNTHESIS
  // The done flag must always agree with the reported mode.
  a_done_matches_mode: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (playback_done == (play_mode == MODE_STOP)))
    else $error("playback_done disagrees with play_mode");

  // A beat that issued no frame carries a zero frame number.
  a_no_issue_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_issued) |-> (issued_frame == '0))
    else $error("issued_frame nonzero without frame_issued");

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!full && empty))
    else $error("queues not empty after reset");
`endif

endmodule

// File: test/tb_animation_frame_sequencer_unit.sv
// Self-checking testbench for animation_frame_sequencer_unit: a queued command driver,
// a result monitor, an in-bench sequencer predictor and an APB range-register writer.
// Depends on afs_pkg and the RTL top level only.
module tb_animation_frame_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afs_pkg::*;

  localparam int     NUM_SETTINGS     = 9;
  localparam int     RANDOM_PER_PHASE = 80;
  localparam int     BURST_STEPS      = 260;
  localparam int     HOLD_CYCLES      = 400;
  localparam int     WATCHDOG_LIMIT   = 4000;
  localparam int     MAX_REPORTS      = 10;
  localparam longint STEP_MAX         = (longint'(1) << (STEP_BITS - 1)) - 1;
  localparam longint STEP_MIN         = -STEP_MAX - 1;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       push     = 1'b0;
  logic                       full;
  logic [2:0]                 operation = OP_STOP;
  logic                       setting  = 1'b0;
  logic                       empty;
  logic                       pop      = 1'b0;
  logic                       frame_issued;
  frame_t                     issued_frame;
  frame_t                     upcoming_frame;
  logic [1:0]                 play_mode;
  logic                       playback_done;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   paddr    = '0;
  logic [CFG_DATA_BITS-1:0]   pwdata   = '0;
  logic [CFG_DATA_BITS-1:0]   prdata;
  logic                       pready;

  animation_frame_sequencer_unit dut (
    .clk, .rst, .push, .full, .operation, .setting, .empty, .pop,
    .frame_issued, .issued_frame, .upcoming_frame, .play_mode, .playback_done,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Predictor copy of the range registers and playback state.
  frame_t                 cfg_start      = frame_t'(RESET_START);
  frame_t                 cfg_end        = frame_t'(RESET_END);
  frame_t                 cfg_delta      = frame_t'(RESET_DELTA);
  frame_t                 seq_next       = frame_t'(RESET_START);
  frame_t                 seq_current    = frame_t'(RESET_START);
  mode_t                  seq_mode       = MODE_STOP;
  logic                   seq_backward   = 1'b0;
  logic                   seq_loop       = 1'b0;
  logic                   seq_palindrome = 1'b0;
  logic                   seq_flipped    = 1'b0;
  logic signed [STEP_BITS-1:0] seq_steps = '0;

  cmd_t command_queue[$];
  res_t frame_expect_q[$];
  cmd_t drv_cmd;

  int sender_idle_pct   = 26;
  int receiver_idle_pct = 74;
  int commands_sent     = 0;
  int results_checked   = 0;
  int error_count       = 0;
  int hold_left         = 0;
  int holds_done        = 0;
  int quiet_cycles      = 0;

  function automatic longint clamp_frame(longint n, longint s, longint e);
    if (n < s) return s;
    if (n > e) return e;
    return n;
  endfunction

  function automatic longint delta_size();
    longint d;
    d = longint'(cfg_delta);
    if (d == 0) return 1;
    return (d < 0) ? -d : d;
  endfunction

  // The effective direction is reversed while a palindrome bounce is active.
  function automatic longint step_toward(longint d);
    return (seq_backward != seq_flipped) ? -d : d;
  endfunction

  function automatic void advance_frame(longint s, longint e, longint d);
    longint n;
    logic   high;
    n = longint'(seq_next) + step_toward(d);
    if (n >= s && n <= e) begin
      seq_next = frame_t'(n);
      return;
    end
    high = (n > e);
    if (seq_loop) begin
      if (seq_palindrome) begin
        seq_flipped = !seq_flipped;
        n = longint'(seq_next) + step_toward(d);
      end else begin
        n = high ? s : e;
      end
    end else if (seq_palindrome) begin
      if (seq_flipped) begin
        seq_flipped = 1'b0;
        seq_mode = MODE_STOP;
        n = high ? e : s;
      end else begin
        seq_flipped = 1'b1;
        n = longint'(seq_next) + step_toward(d);
      end
    end else begin
      n = high ? s : e;
      seq_mode = MODE_STOP;
    end
    seq_next = frame_t'(clamp_frame(n, s, e));
  endfunction

  // A next frame outside the range is left where it is.
  function automatic void reposition_frame(longint s, longint e, longint d);
    if (clamp_frame(longint'(seq_next), s, e) == longint'(seq_next)) begin
      advance_frame(s, e, d);
      advance_frame(s, e, d);
    end
  endfunction

  function automatic res_t predict_sequencer(cmd_t c);
    res_t   r;
    longint s;
    longint e;
    longint d;
    longint st;
    logic   stepping;
    r = '0;
    s = longint'(cfg_start);
    e = longint'(cfg_end);
    d = delta_size();
    case (c.op)
      OP_STOP: begin
        seq_mode = MODE_STOP;
        seq_flipped = 1'b0;
        seq_steps = '0;
      end
      OP_PAUSE: seq_mode = MODE_PAUSE;
      OP_PLAY: begin
        seq_mode = MODE_PLAY;
        seq_flipped = 1'b0;
        seq_steps = '0;
      end
      OP_STEP: begin
        st = longint'(seq_steps);
        if (seq_backward) begin
          if (st > STEP_MIN) st--;
        end else if (st < STEP_MAX) begin
          st++;
        end
        seq_steps = st[STEP_BITS-1:0];
        seq_mode = (st != 0) ? MODE_STEP : MODE_STOP;
      end
      OP_SET_DIR: begin
        if (seq_backward != c.setting) begin
          seq_backward = c.setting;
          reposition_frame(s, e, d);
        end
      end
      OP_SET_LOOP: seq_loop = c.setting;
      OP_SET_PAL: begin
        seq_palindrome = c.setting;
        if (seq_flipped) begin
          seq_flipped = 1'b0;
          reposition_frame(s, e, d);
        end
      end
      OP_DONE: begin
        if (seq_mode == MODE_PLAY || seq_mode == MODE_STEP) begin
          stepping = (seq_mode == MODE_STEP);
          seq_current = seq_next;
          seq_next = frame_t'(clamp_frame(longint'(seq_next), s, e));
          advance_frame(s, e, d);
          if (stepping) begin
            st = longint'(seq_steps);
            st += (st < 0) ? 1 : -1;
            seq_steps = st[STEP_BITS-1:0];
            if (st == 0) seq_mode = MODE_STOP;
          end
          r.frame_issued = 1'b1;
          r.issued_frame = seq_current;
        end
      end
    endcase
    r.upcoming_frame = seq_next;
    r.play_mode = seq_mode;
    r.playback_done = (seq_mode == MODE_STOP);
    return r;
  endfunction

  // Command driver: holds a beat until accepted, otherwise offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        frame_expect_q.push_back(predict_sequencer(drv_cmd));
        commands_sent++;
      end
      if (push && full) begin
        // Keep the same beat on the ports.
      end else if (command_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        drv_cmd = command_queue.pop_front();
        operation <= drv_cmd.op;
        setting <= drv_cmd.setting;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor with random pop idling and occasional long hold-offs that back up the input.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{frame_issued, issued_frame, upcoming_frame, mode_t'(play_mode), playback_done};
        results_checked++;
        if (frame_expect_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: issued=%0b frame=%0d next=%0d mode=%0d",
                     got.frame_issued, got.issued_frame, got.upcoming_frame, got.play_mode);
        end else begin
          want = frame_expect_q.pop_front();
          if (got.frame_issued !== want.frame_issued || got.issued_frame !== want.issued_frame ||
              got.upcoming_frame !== want.upcoming_frame || got.play_mode !== want.play_mode ||
              got.playback_done !== want.playback_done) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display({"mismatch on result %0d: expected issued=%0b frame=%0d next=%0d",
                        " mode=%0d done=%0b"},
                       results_checked, want.frame_issued, want.issued_frame,
                       want.upcoming_frame, want.play_mode, want.playback_done);
              $display({"                       actual   issued=%0b frame=%0d next=%0d",
                        " mode=%0d done=%0b"},
                       got.frame_issued, got.issued_frame, got.upcoming_frame,
                       got.play_mode, got.playback_done);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_done < 3 && command_queue.size() >= 64 &&
                   results_checked >= 200 * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_animation_frame_sequencer_unit: errors");
        $finish;
      end
    end
  end

  task automatic write_range_reg(input logic [1:0] idx, input frame_t val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_BITS'(int'(idx) * 4);
    pwdata <= {{(CFG_DATA_BITS - FRAME_BITS){val[FRAME_BITS-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START: cfg_start = val;
      REG_END:   cfg_end = val;
      default:   cfg_delta = val;
    endcase
  endtask

  task automatic wait_drained();
    while (command_queue.size() != 0 || push || frame_expect_q.size() != 0) @(posedge clk);
  endtask

  // Ranges: small, signed, inverted, full width, near the top and bottom with huge deltas,
  // a single frame, and a mixed-sign one; the last setting is drawn at random.
  int range_starts[NUM_SETTINGS - 1] = '{1, -5, 10, -32768, 32760, -32768, 0, -8};
  int range_ends[NUM_SETTINGS - 1]   = '{20, 5, 3, 32767, 32767, -32760, 0, 12};
  int range_deltas[NUM_SETTINGS - 1] = '{1, -2, 3, 0, 32767, -32768, 5, -3};

  cmd_t directed_cmds[23] = '{
    '{OP_DONE, 1'b0}, '{OP_PLAY, 1'b0}, '{OP_DONE, 1'b0}, '{OP_DONE, 1'b1},
    '{OP_PAUSE, 1'b0}, '{OP_DONE, 1'b0}, '{OP_SET_DIR, 1'b1}, '{OP_SET_DIR, 1'b1},
    '{OP_SET_PAL, 1'b1}, '{OP_PLAY, 1'b1}, '{OP_DONE, 1'b0}, '{OP_SET_PAL, 1'b1},
    '{OP_DONE, 1'b0}, '{OP_SET_LOOP, 1'b1}, '{OP_STEP, 1'b0}, '{OP_DONE, 1'b0},
    '{OP_SET_DIR, 1'b0}, '{OP_STEP, 1'b1}, '{OP_STEP, 1'b0}, '{OP_DONE, 1'b0},
    '{OP_SET_LOOP, 1'b0}, '{OP_STOP, 1'b1}, '{OP_DONE, 1'b1}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed commands run against the reset range.
    foreach (directed_cmds[i]) command_queue.push_back(directed_cmds[i]);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin : setting_phase
      int   s_val;
      int   e_val;
      int   d_val;
      int   pick;
      cmd_t c;
      case (p / 3)
        0: begin sender_idle_pct = 26; receiver_idle_pct = 74; end
        1: begin sender_idle_pct = 74; receiver_idle_pct = 26; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      if (p < NUM_SETTINGS - 1) begin
        s_val = range_starts[p];
        e_val = range_ends[p];
        d_val = range_deltas[p];
      end else begin
        s_val = int'($urandom_range(40)) - 20;
        e_val = s_val + int'($urandom_range(33)) - 3;
        d_val = int'($urandom_range(12)) - 6;
      end
      repeat (3) @(posedge clk);
      write_range_reg(REG_START, frame_t'(s_val));
      write_range_reg(REG_END, frame_t'(e_val));
      write_range_reg(REG_DELTA, frame_t'(d_val));

      // Long step runs drive the step count into saturation, forward and then backward.
      if (p == 3 || p == 7) begin
        command_queue.push_back('{OP_SET_DIR, (p == 7)});
        repeat (BURST_STEPS) command_queue.push_back('{OP_STEP, 1'($urandom_range(1))});
      end
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        c.setting = 1'($urandom_range(1));
        if (pick < 45)      c.op = OP_DONE;
        else if (pick < 53) c.op = OP_PLAY;
        else if (pick < 63) c.op = OP_STEP;
        else if (pick < 72) c.op = OP_SET_DIR;
        else if (pick < 79) c.op = OP_SET_LOOP;
        else if (pick < 87) c.op = OP_SET_PAL;
        else if (pick < 93) c.op = OP_STOP;
        else                c.op = OP_PAUSE;
        command_queue.push_back(c);
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    $display("Run covered %0d commands over %0d range settings, %0d results checked, %0d hold-offs.",
             commands_sent, NUM_SETTINGS + 1, results_checked, holds_done);
    $display("Exercised play, pause, stop, step saturation, direction and palindrome moves, ends.");
    if (error_count == 0 && frame_expect_q.size() == 0) begin
      $display("tb_animation_frame_sequencer_unit: clean");
    end else begin
      $display("%0d failures, %0d results never arrived", error_count, frame_expect_q.size());
      $display("tb_animation_frame_sequencer_unit: errors");
    end
    $finish;
  end

endmodule

// File: animation_frame_sequencer_unit.f
src/afs_pkg.sv
src/afs_front.sv
src/afs_res_fifo.sv
src/afs_back.sv
src/animation_frame_sequencer_unit.sv
test/tb_animation_frame_sequencer_unit.sv
